[rtl/core/lrutlb_pkg.sv]
package lrutlb_pkg;

   // Default geometry of the buffer.
   localparam int LRUTLB_ENTRIES  = 16;
   localparam int LRUTLB_TAG_BITS = 32;

   // Fixed widths of the channel fields.
   localparam int PAGE_TAG_W = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int COUNT_W    = 32;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic lookup;   // Compare the incoming tag and capture the lookup.
      logic commit;   // Apply the recency update and fill, write the result.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free; // The result register can take a new beat this cycle.
   } status_type;

endpackage

[rtl/core/lrutlb_if.sv]
// Lookup request channel: one page tag per beat.
interface lrutlb_req_if
   import lrutlb_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [PAGE_TAG_W-1:0] page_tag;

   modport source (output valid, output page_tag, input ready);
   modport sink (input valid, input page_tag, output ready);
endinterface

// Lookup response channel: outcome and running totals per beat.
interface lrutlb_rsp_if
   import lrutlb_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_OUT_W-1:0] slot;
   logic [COUNT_W-1:0]    hit_total;
   logic [COUNT_W-1:0]    miss_total;

   modport source (output valid, output hit, output slot, output hit_total,
                   output miss_total, input ready);
   modport sink (input valid, input hit, input slot, input hit_total,
                 input miss_total, output ready);
endinterface

[rtl/core/lru_tlb_lookup.sv]
// Fully associative translation lookaside buffer with least-recently-used
// replacement. Each request beat carries a page tag, which is compared on its
// low TAG_BITS bits against all ENTRIES valid entries at once. A hit promotes
// that entry to most recent; a miss fills the next unused entry, or replaces
// the least recent one once all are filled, and makes it most recent. Each
// response beat reports hit or miss, the entry used, and saturating hit and
// miss totals. The tag compare across all entries runs in the cycle the request
// is accepted and its result is registered; the recency list update, fill and
// result write then run in the update state. The request side is not ready in
// that state, and the update also waits there while the response register
// still holds a beat that has not been taken. No clearing pass is needed after
// reset.
module lru_tlb_lookup
   import lrutlb_pkg::*;
#(
   parameter int ENTRIES  = LRUTLB_ENTRIES,
   parameter int TAG_BITS = LRUTLB_TAG_BITS
) (
   input  logic         clock,
   input  logic         reset,
   lrutlb_req_if.sink   req_ch,
   lrutlb_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   // Sequencing of lookup and commit.
   lrutlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Entry storage, compare, recency list and result register.
   lrutlb_datapath #(
      .ENTRIES  (ENTRIES),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .page_tag       (req_ch.page_tag),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_hit        (rsp_ch.hit),
      .rsp_slot       (rsp_ch.slot),
      .rsp_hit_total  (rsp_ch.hit_total),
      .rsp_miss_total (rsp_ch.miss_total)
   );

endmodule

[rtl/core/lrutlb_ctrl.sv]
module lrutlb_ctrl
   import lrutlb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A request is taken only while idle; the update waits for a free result slot.
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.lookup = req_valid;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.commit = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/lrutlb_datapath.sv]
module lrutlb_datapath
   import lrutlb_pkg::*;
#(
   parameter int ENTRIES  = LRUTLB_ENTRIES,
   parameter int TAG_BITS = LRUTLB_TAG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [PAGE_TAG_W-1:0] page_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [COUNT_W-1:0]    rsp_hit_total,
   output logic [COUNT_W-1:0]    rsp_miss_total
);

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   // Entry storage: tags, valid bits and the recency list (position 0 is newest).
   logic [TAG_BITS-1:0] tag_ff [ENTRIES];
   logic [TAG_BITS-1:0] tag_in [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff;
   logic [ENTRIES-1:0]  valid_in;
   logic [SLOT_W-1:0]   rec_ff [ENTRIES];
   logic [SLOT_W-1:0]   rec_in [ENTRIES];
   logic [CNT_W-1:0]    filled_ff;
   logic [CNT_W-1:0]    filled_in;
   logic [COUNT_W-1:0]  hit_cnt_ff;
   logic [COUNT_W-1:0]  hit_cnt_in;
   logic [COUNT_W-1:0]  miss_cnt_ff;
   logic [COUNT_W-1:0]  miss_cnt_in;

   // Lookup stage results.
   logic [TAG_BITS-1:0] look_tag_ff;
   logic                look_hit_ff;
   logic [SLOT_W-1:0]   look_slot_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_hit_total_ff;
   logic [COUNT_W-1:0]    rsp_miss_total_ff;

   logic [TAG_BITS+PAGE_TAG_W-1:0] tag_wide;
   logic [TAG_BITS-1:0]            tag_cur;
   logic [ENTRIES-1:0]             match;
   logic                           any_match;
   logic [SLOT_W-1:0]              match_slot;
   logic                           full;
   logic [SLOT_W-1:0]              hit_pos;
   logic [SLOT_W-1:0]              upd_pos;
   logic [SLOT_W-1:0]              upd_slot;
   logic [SLOT_W+SLOT_OUT_W-1:0]   slot_wide;

   // Only the low TAG_BITS bits of the page tag take part in the lookup.
   assign tag_wide = {{TAG_BITS{1'b0}}, page_tag};
   assign tag_cur  = tag_wide[TAG_BITS-1:0];

   // Compare the incoming tag with every valid entry; lowest match wins.
   always_comb begin
      match_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == tag_cur);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_slot = SLOT_W'(i);
         end
      end
   end
   assign any_match = |match;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         look_tag_ff  <= tag_cur;
         look_hit_ff  <= any_match;
         look_slot_ff <= match_slot;
      end
   end

   // Find where the hit slot sits in the filled part of the recency list.
   always_comb begin
      hit_pos = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < filled_ff) && (rec_ff[i] == look_slot_ff)) begin
            hit_pos = SLOT_W'(i);
         end
      end
   end

   assign full = (filled_ff == CNT_W'(ENTRIES));

   // Pick the slot to use and the recency position it is promoted from.
   always_comb begin
      priority if (look_hit_ff) begin
         upd_slot = look_slot_ff;
         upd_pos  = hit_pos;
      end else if (!full) begin
         upd_slot = filled_ff[SLOT_W-1:0];
         upd_pos  = filled_ff[SLOT_W-1:0];
      end else begin
         upd_slot = rec_ff[ENTRIES-1];
         upd_pos  = SLOT_W'(ENTRIES - 1);
      end
   end

   // Commit: promote the slot to the front, fill on a miss, bump the counters.
   always_comb begin
      tag_in      = tag_ff;
      valid_in    = valid_ff;
      rec_in      = rec_ff;
      filled_in   = filled_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (cmd.commit) begin
         for (int i = 1; i < ENTRIES; i++) begin
            if (SLOT_W'(i) <= upd_pos) begin
               rec_in[i] = rec_ff[i-1];
            end
         end
         rec_in[0] = upd_slot;
         if (look_hit_ff) begin
            if (hit_cnt_ff != '1) begin
               hit_cnt_in = hit_cnt_ff + 1'b1;
            end
         end else begin
            tag_in[upd_slot]   = look_tag_ff;
            valid_in[upd_slot] = 1'b1;
            if (!full) begin
               filled_in = filled_ff + 1'b1;
            end
            if (miss_cnt_ff != '1) begin
               miss_cnt_in = miss_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      rec_ff <= rec_in;
      if (reset) begin
         valid_ff    <= '0;
         filled_ff   <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         filled_ff   <= filled_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   // Result register: loaded on commit, emptied when the beat is taken.
   assign slot_wide       = {{SLOT_OUT_W{1'b0}}, upd_slot};
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff        <= look_hit_ff;
         rsp_slot_ff       <= slot_wide[SLOT_OUT_W-1:0];
         rsp_hit_total_ff  <= hit_cnt_in;
         rsp_miss_total_ff <= miss_cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_hit_total  = rsp_hit_total_ff;
   assign rsp_miss_total = rsp_miss_total_ff;

   // The fill count never passes the number of entries.
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(ENTRIES))
      else $error("fill count exceeds entry count");

   // Exactly as many entries are valid as have been filled.
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(filled_ff))
      else $error("valid bits disagree with fill count");

   // A commit only happens when the result register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result register is occupied");

   // A commit always presents a result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not produce a result");

endmodule
